// ===== src/y4m_pkg.sv =====
// Shared constants, codes and the result type for the YUV4MPEG2 header parser.
// No dependencies; used by y4m_result_check, y4m_stream_header_parser and the testbench.
package y4m_pkg;

   localparam int BYTE_W     = 8;
   localparam int OUT_W      = 15;
   localparam int PREFIX_LEN = 10;
   localparam int POS_W      = 4;
   localparam int RATE_LIMIT = 240;

   // byte codes
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_W     = 8'h57;
   localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
   localparam logic [BYTE_W-1:0] CH_F     = 8'h46;

   // token scanner phase
   localparam logic [2:0] PH_BETWEEN = 3'd0;
   localparam logic [2:0] PH_LEAD    = 3'd1;
   localparam logic [2:0] PH_FIRST   = 3'd2;
   localparam logic [2:0] PH_SECOND  = 3'd3;
   localparam logic [2:0] PH_IGNORE  = 3'd4;

   // token kind
   localparam logic [1:0] KIND_IGNORED = 2'd0;
   localparam logic [1:0] KIND_W       = 2'd1;
   localparam logic [1:0] KIND_H       = 2'd2;
   localparam logic [1:0] KIND_F       = 2'd3;

   typedef struct packed {
      logic             header_ok;
      logic [OUT_W-1:0] frame_width;
      logic [OUT_W-1:0] frame_height;
      logic [OUT_W-1:0] rate_num;
      logic [OUT_W-1:0] rate_den;
   } rsp_type;

   // "YUV4MPEG2 " one byte per position
   function automatic logic [BYTE_W-1:0] magic_byte(input logic [POS_W-1:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         4'd0:    b = 8'h59; // Y
         4'd1:    b = 8'h55; // U
         4'd2:    b = 8'h56; // V
         4'd3:    b = 8'h34; // 4
         4'd4:    b = 8'h4D; // M
         4'd5:    b = 8'h50; // P
         4'd6:    b = 8'h45; // E
         4'd7:    b = 8'h47; // G
         4'd8:    b = 8'h32; // 2
         4'd9:    b = 8'h20; // space
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== src/y4m_result_check.sv =====
// Header validity check and result formatting at end of line.
// Depends on y4m_pkg (rsp_type, RATE_LIMIT, OUT_W).
module y4m_result_check import y4m_pkg::*; #(
   parameter int DIM_W = 15
) (
   input  logic             prefix_done,
   input  logic             line_bad,
   input  logic [DIM_W-1:0] width,
   input  logic [DIM_W-1:0] height,
   input  logic [DIM_W-1:0] num,
   input  logic [DIM_W-1:0] den,
   output rsp_type          result
);

   localparam int RATE_W = DIM_W + 8;

   logic [RATE_W-1:0] rate_cap;
   logic              rate_ok;
   logic              ok;

   // exact num/den <= 240 via num <= 240*den
   assign rate_cap = RATE_W'(den) * RATE_W'(RATE_LIMIT);
   assign rate_ok  = RATE_W'(num) <= rate_cap;

   assign ok = prefix_done && !line_bad &&
               (width != '0) && (height != '0) &&
               !width[0] && !height[0] && rate_ok;

   always_comb begin
      result.header_ok    = ok;
      result.frame_width  = ok ? OUT_W'(width)  : '0;
      result.frame_height = ok ? OUT_W'(height) : '0;
      result.rate_num     = ok ? OUT_W'(num)    : '0;
      result.rate_den     = ok ? OUT_W'(den)    : OUT_W'(1);
   end

endmodule

// ===== src/y4m_stream_header_parser.sv =====
// Top level of the YUV4MPEG2 stream header parser: byte scanner and result register.
// Depends on y4m_pkg and y4m_result_check.
//
// Takes one header byte per beat on req_* and returns one result beat on rsp_* for
// every newline byte; carriage returns are dropped and all other bytes produce no
// result. The line must open with "YUV4MPEG2 ", after which W<n>, H<n> and
// F<num>:<den> tokens are decoded (decimal, 1..MAX_DIM, later tokens override
// earlier ones). header_ok needs width and height present, nonzero and even and
// num <= 240*den; when it is low the fields read 0 / 0 / 0 / 1. A line reaching
// MAX_LINE kept bytes is failed and the rest through the newline is dropped.
// Throughput is one byte per clock while req_ready is high: each byte needs one decimal
// shift-add step and a small state update, and the newline byte also flushes the
// open token and runs the 240*den compare, all combinationally. The result
// appears on rsp_* the cycle after the newline beat and sits in an output
// register; req_ready stays high while that register is empty or being drained,
// and drops only while a result is held and the receiver stalls, so then every
// byte waits until the result leaves. No clearing pass after reset.
module y4m_stream_header_parser import y4m_pkg::*; #(
   parameter int MAX_LINE = 4096,
   parameter int MAX_DIM  = 16384
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_header_ok,
   output logic [OUT_W-1:0]  rsp_frame_width,
   output logic [OUT_W-1:0]  rsp_frame_height,
   output logic [OUT_W-1:0]  rsp_rate_num,
   output logic [OUT_W-1:0]  rsp_rate_den
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int ACC_W = DIM_W + 4;          // room for value*10+9
   localparam int KL_W  = $clog2(MAX_LINE + 1);

   // scanner state
   logic [KL_W-1:0]  kept_len_ff,   kept_len_in;
   logic [POS_W-1:0] prefix_pos_ff, prefix_pos_in;
   logic [2:0]       phase_ff,      phase_in;
   logic [1:0]       kind_ff,       kind_in;
   logic [DIM_W-1:0] part_ff,       part_in;
   logic             part_dig_ff,   part_dig_in;
   logic [DIM_W-1:0] width_ff,      width_in;
   logic [DIM_W-1:0] height_ff,     height_in;
   logic [DIM_W-1:0] num_ff,        num_in;
   logic [DIM_W-1:0] den_ff,        den_in;
   logic             failed_ff,     failed_in;
   logic             discard_ff,    discard_in;

   // result register
   logic             rsp_valid_ff,  rsp_valid_in;
   rsp_type          rsp_ff,        rsp_in;

   logic             req_fire;
   logic             is_ws;
   logic             is_digit;
   logic             is_lf;
   logic [KL_W-1:0]  kl_next;

   // token flush (whitespace after a number, or newline)
   logic             part_good;
   logic             fl_failed;
   logic [DIM_W-1:0] fl_width;
   logic [DIM_W-1:0] fl_height;
   logic [DIM_W-1:0] fl_den;

   // one value character
   logic [2:0]       vc_phase;
   logic [DIM_W-1:0] vc_part;
   logic             vc_dig;
   logic             vc_good;
   logic [ACC_W-1:0] vc_acc;
   logic [2:0]       vc_phase_out;
   logic [DIM_W-1:0] vc_part_out;
   logic             vc_dig_out;
   logic [DIM_W-1:0] vc_num_out;
   logic             vc_failed_out;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_lf     = req_data_byte == CH_LF;
   assign is_ws     = req_data_byte inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
   assign is_digit  = req_data_byte inside {[CH_ZERO:CH_NINE]};
   assign kl_next   = kept_len_ff + KL_W'(1);

   // close the open number
   always_comb begin
      part_good = part_dig_ff && (part_ff != '0);
      fl_failed = failed_ff;
      fl_width  = width_ff;
      fl_height = height_ff;
      fl_den    = den_ff;
      if (phase_ff == PH_FIRST) begin
         if (kind_ff == KIND_F || !part_good) begin
            fl_failed = 1'b1;         // F needs a colon; empty or zero number
         end else if (kind_ff == KIND_W) begin
            fl_width = part_ff;
         end else if (kind_ff == KIND_H) begin
            fl_height = part_ff;
         end
      end else if (phase_ff == PH_SECOND) begin
         if (!part_good) begin
            fl_failed = 1'b1;
         end else begin
            fl_den = part_ff;
         end
      end
   end

   // digit / colon step; a lead letter starts a fresh number
   always_comb begin
      vc_phase = (phase_ff == PH_LEAD) ? PH_FIRST : phase_ff;
      vc_part  = (phase_ff == PH_LEAD) ? '0 : part_ff;
      vc_dig   = (phase_ff == PH_LEAD) ? 1'b0 : part_dig_ff;
      vc_good  = vc_dig && (vc_part != '0);
      vc_acc   = (ACC_W'(vc_part) << 3) + (ACC_W'(vc_part) << 1) +
                 ACC_W'(req_data_byte[3:0]);

      vc_phase_out  = vc_phase;
      vc_part_out   = vc_part;
      vc_dig_out    = vc_dig;
      vc_num_out    = num_ff;
      vc_failed_out = failed_ff;
      if (vc_phase == PH_FIRST && kind_ff == KIND_F && req_data_byte == CH_COLON) begin
         if (!vc_good) begin
            vc_failed_out = 1'b1;
         end else begin
            vc_num_out   = vc_part;
            vc_part_out  = '0;
            vc_dig_out   = 1'b0;
            vc_phase_out = PH_SECOND;
         end
      end else if (is_digit) begin
         vc_part_out = DIM_W'(vc_acc);
         vc_dig_out  = 1'b1;
         if (vc_acc > ACC_W'(MAX_DIM)) begin
            vc_failed_out = 1'b1;
         end
      end else begin
         vc_failed_out = 1'b1;        // stray character in a number, or extra colon
      end
   end

   // next scanner state
   always_comb begin
      kept_len_in   = kept_len_ff;
      prefix_pos_in = prefix_pos_ff;
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      part_in       = part_ff;
      part_dig_in   = part_dig_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      failed_in     = failed_ff;
      discard_in    = discard_ff;

      if (req_fire) begin
         if (is_lf) begin
            // every newline returns the scanner to its reset state
            kept_len_in   = '0;
            prefix_pos_in = '0;
            phase_in      = PH_BETWEEN;
            kind_in       = KIND_IGNORED;
            part_in       = '0;
            part_dig_in   = 1'b0;
            width_in      = '0;
            height_in     = '0;
            num_in        = '0;
            den_in        = DIM_W'(1);
            failed_in     = 1'b0;
            discard_in    = 1'b0;
         end else if (!discard_ff && req_data_byte != CH_CR) begin
            kept_len_in = kl_next;
            if (!failed_ff) begin
               if (prefix_pos_ff < POS_W'(PREFIX_LEN)) begin
                  if (req_data_byte != magic_byte(prefix_pos_ff)) begin
                     failed_in = 1'b1;
                  end else begin
                     prefix_pos_in = prefix_pos_ff + POS_W'(1);
                  end
               end else begin
                  case (phase_ff)
                     PH_BETWEEN: begin
                        if (!is_ws) begin
                           phase_in = PH_LEAD;
                           if (req_data_byte == CH_W) begin
                              kind_in = KIND_W;
                           end else if (req_data_byte == CH_H) begin
                              kind_in = KIND_H;
                           end else if (req_data_byte == CH_F) begin
                              kind_in = KIND_F;
                           end else begin
                              kind_in  = KIND_IGNORED;
                              phase_in = PH_IGNORE;
                           end
                        end
                     end
                     PH_LEAD, PH_FIRST, PH_SECOND: begin
                        if (is_ws) begin
                           // bare letter closes silently; a number is flushed
                           phase_in    = PH_BETWEEN;
                           kind_in     = KIND_IGNORED;
                           part_in     = '0;
                           part_dig_in = 1'b0;
                           failed_in   = fl_failed;
                           width_in    = fl_width;
                           height_in   = fl_height;
                           den_in      = fl_den;
                        end else begin
                           phase_in    = vc_phase_out;
                           part_in     = vc_part_out;
                           part_dig_in = vc_dig_out;
                           num_in      = vc_num_out;
                           failed_in   = vc_failed_out;
                        end
                     end
                     default: begin
                        if (is_ws) begin
                           phase_in = PH_BETWEEN;
                           kind_in  = KIND_IGNORED;
                        end
                     end
                  endcase
               end
            end
            if (kl_next >= KL_W'(MAX_LINE)) begin
               discard_in = 1'b1;
               failed_in  = 1'b1;
            end
         end
      end
   end

   // end-of-line check on the flushed stores
   y4m_result_check #(
      .DIM_W (DIM_W)
   ) u_check (
      .prefix_done (prefix_pos_ff == POS_W'(PREFIX_LEN)),
      .line_bad    (fl_failed || discard_ff),
      .width       (fl_width),
      .height      (fl_height),
      .num         (num_ff),
      .den         (fl_den),
      .result      (rsp_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && is_lf) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_len_ff   <= '0;
         prefix_pos_ff <= '0;
         phase_ff      <= PH_BETWEEN;
         kind_ff       <= KIND_IGNORED;
         part_ff       <= '0;
         part_dig_ff   <= 1'b0;
         width_ff      <= '0;
         height_ff     <= '0;
         num_ff        <= '0;
         den_ff        <= DIM_W'(1);
         failed_ff     <= 1'b0;
         discard_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         kept_len_ff   <= kept_len_in;
         prefix_pos_ff <= prefix_pos_in;
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         part_ff       <= part_in;
         part_dig_ff   <= part_dig_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         num_ff        <= num_in;
         den_ff        <= den_in;
         failed_ff     <= failed_in;
         discard_ff    <= discard_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, loaded on the newline beat only
   always_ff @(posedge clock) begin
      if (req_fire && is_lf) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_header_ok    = rsp_ff.header_ok;
   assign rsp_frame_width  = rsp_ff.frame_width;
   assign rsp_frame_height = rsp_ff.frame_height;
   assign rsp_rate_num     = rsp_ff.rate_num;
   assign rsp_rate_den     = rsp_ff.rate_den;

   // a new result only follows a newline beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid && req_ready && req_data_byte == CH_LF))
      else $error("result raised without a newline beat");

   // discard mode always implies a failed line
   assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> failed_ff)
      else $error("discarding while line not failed");

   // kept byte count never passes the line limit
   assert property (@(posedge clock) disable iff (reset)
      kept_len_ff <= KL_W'(MAX_LINE))
      else $error("kept length beyond line limit");

   // prefix match position never runs past the magic text
   assert property (@(posedge clock) disable iff (reset)
      prefix_pos_ff <= POS_W'(PREFIX_LEN))
      else $error("prefix position out of range");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for y4m_stream_header_parser: byte stream in, one header result
// per newline out, checked against a line-parser model kept inside this file.
// Depends on y4m_pkg and the parser RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import y4m_pkg::*;

   localparam int LINE_MAX     = 4096;
   localparam int DIM_MAX      = 16384;
   localparam int RATE_CAP     = 240;
   localparam int MAGIC_LEN    = 10;
   localparam int RANDOM_BYTES = 1850;
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int PRINT_CAP    = 100;

   // header result as it reads when the line was rejected
   localparam rsp_type HDR_BAD = '{1'b0, 15'd0, 15'd0, 15'd0, 15'd1};
   localparam rsp_type HDR_2X2 = '{1'b1, 15'd2, 15'd2, 15'd0, 15'd1};
   localparam rsp_type HDR_TOP = '{1'b1, 15'd16384, 15'd16384, 15'd240, 15'd1};

   logic              clock;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready     = 1'b0;
   logic              rsp_header_ok;
   logic [OUT_W-1:0]  rsp_frame_width;
   logic [OUT_W-1:0]  rsp_frame_height;
   logic [OUT_W-1:0]  rsp_rate_num;
   logic [OUT_W-1:0]  rsp_rate_den;

   y4m_stream_header_parser #(
      .MAX_LINE (LINE_MAX),
      .MAX_DIM  (DIM_MAX)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_header_ok    (rsp_header_ok),
      .rsp_frame_width  (rsp_frame_width),
      .rsp_frame_height (rsp_frame_height),
      .rsp_rate_num     (rsp_rate_num),
      .rsp_rate_den     (rsp_rate_den)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Line parser model: own copy of the scanner state
   // ------------------------------------------------------------------
   string            y4m_magic = "YUV4MPEG2 ";
   logic [12:0]      kept_cnt;
   logic [3:0]       magic_pos;
   logic [2:0]       scan_phase;
   logic [1:0]       scan_kind;
   logic [17:0]      digits_val;     // wide enough for one digit past the cap
   bit               digits_seen;
   logic [OUT_W-1:0] width_seen;
   logic [OUT_W-1:0] height_seen;
   logic [OUT_W-1:0] num_seen;
   logic [OUT_W-1:0] den_seen;
   bit               line_bad;
   bit               dropping;

   rsp_type headers_due [$];         // expected header results, oldest first
   bit      use_typed    = 1'b0;     // directed row carries a hand-written result
   rsp_type typed_header = HDR_BAD;

   int mismatch_count  = 0;
   int headers_checked = 0;
   int headers_good    = 0;
   int bytes_sent      = 0;
   int cycle_count     = 0;
   int send_idle_pct   = 0;
   int stall_pct       = 0;

   function automatic void clear_line();
      kept_cnt    = '0;
      magic_pos   = '0;
      scan_phase  = PH_BETWEEN;
      scan_kind   = KIND_IGNORED;
      digits_val  = '0;
      digits_seen = 1'b0;
      width_seen  = '0;
      height_seen = '0;
      num_seen    = '0;
      den_seen    = 15'd1;
      line_bad    = 1'b0;
      dropping    = 1'b0;
   endfunction

   function automatic bit is_blank(logic [BYTE_W-1:0] b);
      return b inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
   endfunction

   function automatic bit number_ok();
      return digits_seen && digits_val != 0;
   endfunction

   // whitespace or newline closes the number being read
   function automatic void close_number();
      if (scan_phase == PH_FIRST) begin
         if (scan_kind == KIND_F || !number_ok()) begin
            line_bad = 1'b1;   // F without a colon, or empty/zero value
         end else if (scan_kind == KIND_W) begin
            width_seen = digits_val[OUT_W-1:0];
         end else if (scan_kind == KIND_H) begin
            height_seen = digits_val[OUT_W-1:0];
         end
      end else if (scan_phase == PH_SECOND) begin
         if (!number_ok()) begin
            line_bad = 1'b1;
         end else begin
            den_seen = digits_val[OUT_W-1:0];
         end
      end
      scan_phase  = PH_BETWEEN;
      scan_kind   = KIND_IGNORED;
      digits_val  = '0;
      digits_seen = 1'b0;
   endfunction

   function automatic void number_char(logic [BYTE_W-1:0] b);
      if (scan_phase == PH_FIRST && scan_kind == KIND_F && b == CH_COLON) begin
         if (!number_ok()) begin
            line_bad = 1'b1;
         end else begin
            num_seen    = digits_val[OUT_W-1:0];
            digits_val  = '0;
            digits_seen = 1'b0;
            scan_phase  = PH_SECOND;
         end
      end else if (b >= CH_ZERO && b <= CH_NINE) begin
         digits_val  = digits_val * 10 + (b - CH_ZERO);
         digits_seen = 1'b1;
         if (digits_val > DIM_MAX) line_bad = 1'b1;
      end else begin
         line_bad = 1'b1;   // stray character, second colon included
      end
   endfunction

   function automatic void scan_kept(logic [BYTE_W-1:0] b);
      bit blank;
      if (magic_pos < MAGIC_LEN) begin
         if (b != y4m_magic[magic_pos]) begin
            line_bad = 1'b1;
         end else begin
            magic_pos++;
         end
         return;
      end
      blank = is_blank(b);
      case (scan_phase)
         PH_BETWEEN: begin
            if (!blank) begin
               scan_phase = PH_LEAD;
               if (b == CH_W) begin
                  scan_kind = KIND_W;
               end else if (b == CH_H) begin
                  scan_kind = KIND_H;
               end else if (b == CH_F) begin
                  scan_kind = KIND_F;
               end else begin
                  scan_kind  = KIND_IGNORED;
                  scan_phase = PH_IGNORE;
               end
            end
         end
         PH_LEAD: begin
            if (blank) begin
               // bare letter: nothing to store
               scan_phase = PH_BETWEEN;
               scan_kind  = KIND_IGNORED;
            end else begin
               scan_phase  = PH_FIRST;
               digits_val  = '0;
               digits_seen = 1'b0;
               number_char(b);
            end
         end
         PH_FIRST, PH_SECOND: begin
            if (blank) begin
               close_number();
            end else begin
               number_char(b);
            end
         end
         default: begin
            if (blank) begin
               scan_phase = PH_BETWEEN;
               scan_kind  = KIND_IGNORED;
            end
         end
      endcase
   endfunction

   // one accepted byte; a newline yields the header result
   function automatic void parse_header_byte(input logic [BYTE_W-1:0] b,
                                             output bit line_done, output rsp_type hdr);
      bit good;
      line_done = 1'b0;
      hdr       = HDR_BAD;
      if (b == CH_LF) begin
         if (!dropping && !line_bad) close_number();
         good = !dropping && !line_bad && magic_pos == MAGIC_LEN &&
                width_seen != 0 && height_seen != 0 &&
                !width_seen[0] && !height_seen[0] &&
                num_seen <= RATE_CAP * den_seen;
         line_done = 1'b1;
         if (good) hdr = '{1'b1, width_seen, height_seen, num_seen, den_seen};
         clear_line();
      end else if (!dropping && b != CH_CR) begin
         kept_cnt++;
         if (!line_bad) scan_kept(b);
         if (kept_cnt >= LINE_MAX) begin
            // overlong line: fail it and drop everything up to the newline
            dropping = 1'b1;
            line_bad = 1'b1;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_count < PRINT_CAP) begin
         $display("[%0t] result %0d %s: got %0d, expected %0d",
                  $time, headers_checked, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic check_header(rsp_type want);
      if (rsp_header_ok !== want.header_ok)
         report_mismatch("header_ok", rsp_header_ok, want.header_ok);
      if (rsp_frame_width !== want.frame_width)
         report_mismatch("frame_width", rsp_frame_width, want.frame_width);
      if (rsp_frame_height !== want.frame_height)
         report_mismatch("frame_height", rsp_frame_height, want.frame_height);
      if (rsp_rate_num !== want.rate_num)
         report_mismatch("rate_num", rsp_rate_num, want.rate_num);
      if (rsp_rate_den !== want.rate_den)
         report_mismatch("rate_den", rsp_rate_den, want.rate_den);
      headers_checked++;
      if (want.header_ok) headers_good++;
   endtask

   // Both channels sampled at the rising edge, before the block's own updates land.
   // The result beat is checked first, so a newline beat in the same cycle queues
   // behind whatever is already due.
   rsp_type predicted;
   bit      line_done;

   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         clear_line();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (headers_due.size() == 0) begin
               report_mismatch("result beat with none due", 1, 0);
            end else begin
               check_header(headers_due.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            parse_header_byte(req_data_byte, line_done, predicted);
            if (line_done) begin
               headers_due.insert(headers_due.size(), use_typed ? typed_header : predicted);
            end
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, headers_due.size());
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Byte driver: called at a falling edge, returns at the falling edge after
   // the beat is taken. Valid is left high so back-to-back beats never glitch.
   // ------------------------------------------------------------------
   logic [BYTE_W-1:0] line_bytes [$];

   function automatic void append_byte(logic [BYTE_W-1:0] b);
      line_bytes.insert(line_bytes.size(), b);
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data_byte = b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_line(input bit sprinkle_cr);
      foreach (line_bytes[i]) begin
         if (sprinkle_cr && $urandom_range(99) < 3) send_byte(CH_CR);
         send_byte(line_bytes[i]);
      end
   endtask

   // sender holds off until every queued result has come back
   task automatic wait_headers_drained();
      while (headers_due.size() != 0) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endfunction

   logic [BYTE_W-1:0] blank_chars [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

   function automatic void add_blanks();
      int n;
      n = ($urandom_range(9) < 7) ? 1 : $urandom_range(2, 3);
      repeat (n) begin
         append_byte(($urandom_range(1) == 0) ? CH_SPACE : blank_chars[$urandom_range(3)]);
      end
   endfunction

   // dimension digits: mostly plausible even sizes, plus the edges around the cap
   function automatic string dim_digits();
      int v;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: v = 2 * $urandom_range(1, 1000);
         5:             v = $urandom_range(1, DIM_MAX);
         6:             v = DIM_MAX;
         7:             v = DIM_MAX + 1 + $urandom_range(0, 90000);
         8:             v = 0;
         default:       v = 2 * $urandom_range(0, 4) + 1;
      endcase
      return ($urandom_range(9) == 0) ? {"00", $sformatf("%0d", v)} : $sformatf("%0d", v);
   endfunction

   // rate token, often right on the 240 fps boundary
   function automatic string rate_token();
      int den;
      int num;
      den = ($urandom_range(1) == 0) ? 1 : $urandom_range(1, 1001);
      case ($urandom_range(4))
         0:       num = RATE_CAP * den;
         1:       num = RATE_CAP * den + 1;
         2:       num = $urandom_range(1, 60);
         3:       num = $urandom_range(0, DIM_MAX);
         default: num = $urandom_range(1, 30000);
      endcase
      if (num > DIM_MAX && $urandom_range(3) != 0) num = DIM_MAX;
      return $sformatf("F%0d:%0d", num, den);
   endfunction

   localparam int ODD_COUNT = 18;
   string odd_tokens [ODD_COUNT] = '{
      "C420jpeg", "Ip", "A1:1", "XYSCSS=420", "w640", "Z", "F25", "F1:2:3", "W12a",
      "H:4", "F:1", "F1:", "W", "H", "F", "W2:2", "F30:0", "H0"
   };

   // Most lines are well-formed headers with random tokens and spacing; the rest
   // carry a broken magic, a stray byte, or are plain noise.
   task automatic build_random_line();
      int    kind;
      int    k;
      string toks [$];
      string t;
      line_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(24)) append_byte(8'($urandom_range(255)));
      end else begin
         add_text(y4m_magic);
         if (kind < 22) begin
            k = $urandom_range(MAGIC_LEN - 1);
            if ($urandom_range(1) == 0) begin
               while (line_bytes.size() > k) void'(line_bytes.pop_back());
            end else begin
               line_bytes[k] = 8'($urandom_range(255));
            end
         end
         if ($urandom_range(9) != 0) toks.insert(toks.size(), {"W", dim_digits()});
         if ($urandom_range(9) != 0) toks.insert($urandom_range(toks.size()),
                                                 {"H", dim_digits()});
         if ($urandom_range(9) < 6) toks.insert($urandom_range(toks.size()), rate_token());
         if ($urandom_range(6) == 0) toks.insert($urandom_range(toks.size()),
                                                 {"W", dim_digits()});
         repeat ($urandom_range(3)) begin
            if ($urandom_range(3) == 0) begin
               t = $sformatf("%c%c", $urandom_range(8'h21, 8'h7E), $urandom_range(8'h21, 8'h7E));
            end else begin
               t = odd_tokens[$urandom_range(ODD_COUNT - 1)];
            end
            toks.insert($urandom_range(toks.size()), t);
         end
         if ($urandom_range(3) == 0) add_blanks();
         foreach (toks[i]) begin
            add_text(toks[i]);
            if (i < toks.size() - 1 || $urandom_range(3) == 0) add_blanks();
         end
         if (kind >= 90) begin
            line_bytes.insert($urandom_range(line_bytes.size()), 8'($urandom_range(255)));
         end
      end
      append_byte(CH_LF);
   endtask

   // ------------------------------------------------------------------
   // Directed lines: text, filler count ('x'), text after the filler, and a
   // hand-written result where one is obvious. Every row ends in a newline.
   // ------------------------------------------------------------------
   localparam int DIR_ROWS = 25;

   string dir_text [DIR_ROWS] = '{
      "",
      "YUV4MPEG2 W2 H2",
      "YUV4MPEG2 W16384 H16384 F240:1",
      "YUV4MPEG2 W16384 H16384 F16384:69",
      "YUV4MPEG2 W640 H480 F241:1",
      "YUV4MPEG2 W16385 H2",
      "YUV4MPEG2 W0 H2",
      "YUV4MPEG2 W2 H3",
      "YUV4MPEG2 W2 H2 F30",
      "YUV4MPEG2 W2 H2 F30:1:1",
      "YUV4MPEG2 W4 H6 F25:1 W8 H10 F60:1",
      "YUV4",
      "YUV4MPEG3 W2 H2",
      "YUV4MPEG2 \tW720\013H576\014F25:1 C420jpeg Ip A1:1 XYSCSS=420 ",
      "YU\015V4MPEG2 W1\0152 H2\015",
      "YUV4MPEG2 W H W2 H2 F",
      "YUV4MPEG2 W2a H2",
      "YUV4MPEG2 W2 H2 F:1",
      "YUV4MPEG2 W2 H2 F1:",
      "YUV4MPEG2 W2 H2 F1:0",
      "YUV4MPEG2 H2",
      "YUV4MPEG2 W00002 H2 F0240:001",
      "YUV4MPEG2 W2 H2 X",
      "YUV4MPEG2 W2 H2 X",
      "\377\200 W2"
   };
   // 17 text bytes + 4078 filler stays one short of the line limit; +4079 hits it
   int    dir_pad  [DIR_ROWS] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                  0, 0, 4078, 4079, 0};
   string dir_tail [DIR_ROWS] = '{"", "", "", "", "", "", "", "", "", "", "", "", "", "", "",
                                  "", "", "", "", "", "", "", "", "\015W4\015 ", ""};
   bit    dir_typed[DIR_ROWS] = '{1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 0, 1, 1, 0, 0, 0, 1, 1, 1, 1,
                                  1, 0, 0, 1, 1};
   rsp_type dir_want [DIR_ROWS] = '{
      HDR_BAD, HDR_2X2, HDR_TOP, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD,
      HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD,
      HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD, HDR_BAD
   };

   // idle schedule per random phase: none, sender, receiver, both
   int send_idle_sched [4] = '{0, 85, 0, 36};
   int stall_sched     [4] = '{0, 0, 85, 36};

   initial begin
      int target;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int row = 0; row < DIR_ROWS; row++) begin
         line_bytes.delete();
         add_text(dir_text[row]);
         repeat (dir_pad[row]) append_byte("x");
         add_text(dir_tail[row]);
         append_byte(CH_LF);
         use_typed    = dir_typed[row];
         typed_header = dir_want[row];
         send_line(1'b0);
      end
      use_typed = 1'b0;
      wait_headers_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_idle_sched[ph];
         stall_pct     = stall_sched[ph];
         target        = bytes_sent + RANDOM_BYTES / 4;
         while (bytes_sent < target) begin
            build_random_line();
            send_line(1'b1);
         end
         wait_headers_drained();
      end

      req_valid = 1'b0;
      repeat (SETTLE) @(posedge clock);
      $display("%0d directed lines and four random idle phases, %0d bytes in total",
               DIR_ROWS, bytes_sent);
      $display("%0d header results checked (%0d valid), %0d mismatches",
               headers_checked, headers_good, mismatch_count);
      if (mismatch_count == 0 && headers_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== y4m_stream_header_parser.f =====
src/y4m_pkg.sv
src/y4m_result_check.sv
src/y4m_stream_header_parser.sv
tb/sv/tb.sv
